// File: src/swfe_pkg.sv
`default_nettype none
package swfe_pkg;

	// default geometry
	localparam int LANES_DEF        = 4;
	localparam int REGISTERS_DEF    = 4;
	localparam int MEMORY_WORDS_DEF = 4;

	// stream word widths
	localparam int IN_DATA_W  = 88;
	localparam int OUT_DATA_W = 48;

	localparam logic [31:0] CANON_NAN = 32'h7FC0_0000;

	// memory space codes
	localparam logic [1:0] SPACE_GLOBAL = 2'd0;
	localparam logic [1:0] SPACE_SHARED = 2'd1;

	typedef enum logic [1:0] {
		REQ_EXEC    = 2'd0,
		REQ_HOST_WR = 2'd1,
		REQ_HOST_RD = 2'd2,
		REQ_REG_RD  = 2'd3
	} req_type_t;

	typedef enum logic [3:0] {
		OP_ADD  = 4'd0,
		OP_SUB  = 4'd1,
		OP_MUL  = 4'd2,
		OP_DIV  = 4'd3,
		OP_NEG  = 4'd4,
		OP_LD   = 4'd5,
		OP_ST   = 4'd6,
		OP_MOV  = 4'd7,
		OP_HALT = 4'd8
	} opcode_t;

	typedef enum logic [2:0] {
		ST_OK         = 3'd0,
		ST_GLOBAL_OOB = 3'd1,
		ST_SHARED_OOB = 3'd2,
		ST_BAD_SPACE  = 3'd3,
		ST_DIV_ZERO   = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		FOP_ADD = 2'd0,
		FOP_SUB = 2'd1,
		FOP_MUL = 2'd2,
		FOP_DIV = 2'd3
	} fpu_op_t;

	typedef struct packed {
		logic    start;
		fpu_op_t op;
	} fpu_req_t;

	typedef struct packed {
		logic        done;
		logic [31:0] result;
	} fpu_rsp_t;

endpackage
`default_nettype wire

// File: src/simt_warp_float_executor.sv
`default_nettype none
// Channel   Dir  Fields
// s_axis    in   tuser: req_type; tdata: instruction or host request
// m_axis    out  tdata: status, lane flags, read data
//
// Host requests pass through dispatch to the result state, reads by way of a read
// state. An instruction visits every lane in turn, reading and then executing each
// active lane, and waits on the shared FPU for ADD/SUB/MUL/DIV (longest for a DIV
// whose result falls deep into the subnormal range).
// After reset a clearing pass over the register file and both memories runs
// before the first word is taken. A stalled output holds its word; the next
// word is still accepted and waits in the result state.
module simt_warp_float_executor #(
	parameter int LANES        = swfe_pkg::LANES_DEF,
	parameter int REGISTERS    = swfe_pkg::REGISTERS_DEF,
	parameter int MEMORY_WORDS = swfe_pkg::MEMORY_WORDS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// opcode, dest_reg, src_reg, other_reg, use_immediate, immediate,
	// mem_space, use_lane_index, mem_addr, host_addr, host_data
	input  logic [swfe_pkg::IN_DATA_W-1:0]    s_axis_tdata,
	// req_type
	input  logic [1:0]                        s_axis_tuser,
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// status, div_zero_lanes, active_lanes, all_halted, read_data, zero pad
	output logic [swfe_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);
	import swfe_pkg::*;

	localparam int RF_DEPTH  = LANES * REGISTERS;
	localparam int RFW       = $clog2(RF_DEPTH);
	localparam int MAW       = (MEMORY_WORDS > 1) ? $clog2(MEMORY_WORDS) : 1;
	localparam int LW        = (LANES > 1) ? $clog2(LANES) : 1;
	localparam int CLR_DEPTH = (RF_DEPTH > MEMORY_WORDS) ? RF_DEPTH : MEMORY_WORDS;
	localparam int CLW       = $clog2(CLR_DEPTH);

	typedef enum logic [7:0] {
		S_CLEAR    = 8'b0000_0001,
		S_IDLE     = 8'b0000_0010,
		S_DISPATCH = 8'b0000_0100,
		S_HOST_RD  = 8'b0000_1000,
		S_LANE_RD  = 8'b0001_0000,
		S_LANE_EX  = 8'b0010_0000,
		S_FPU_WAIT = 8'b0100_0000,
		S_RESULT   = 8'b1000_0000
	} state_t;

	function automatic logic [RFW-1:0] rf_idx(input logic [5:0] ln, input logic [1:0] r);
		return RFW'(RFW'(ln) * RFW'(REGISTERS) + RFW'(r));
	endfunction

	state_t           state_q;
	logic [CLW-1:0]   clr_q;
	logic [LW-1:0]    lane_q;
	logic [LANES-1:0] lane_active_q, divz_q;
	status_t          status_q;
	logic [31:0]      rdata_q;
	logic             m_tvalid_q;
	logic [OUT_DATA_W-1:0] m_tdata_q;

	// latched request fields
	logic [1:0]  req_q, dreg_q, sreg_q, oreg_q, space_q, haddr_q;
	logic [3:0]  opc_q;
	logic        useimm_q, uselane_q;
	logic [31:0] imm_q, hdata_q;
	logic [7:0]  maddr_q;

	// storage
	logic [31:0] rf_mem [RF_DEPTH];
	logic [31:0] gm_mem [MEMORY_WORDS];
	logic [31:0] sm_mem [MEMORY_WORDS];
	logic [31:0] rf_a_q, rf_b_q, gm_q, sm_q;

	fpu_req_t    fpu_req;
	fpu_rsp_t    fpu_rsp;

	logic        in_acc;
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = state_q == S_IDLE;

	// address checks
	logic [8:0]  mem_addr9, lane9, haddr9;
	logic        mem_ok, st_ok, host_mem_ok, host_lane_ok;
	logic        dreg_ok, sreg_ok, oreg_ok, last_lane, clr_last;
	logic [31:0] a_val, b_val;

	always_comb begin
		mem_addr9    = uselane_q ? 9'(lane_q) : 9'(maddr_q);
		lane9        = 9'(lane_q);
		haddr9       = 9'(haddr_q);
		mem_ok       = mem_addr9 < 9'(MEMORY_WORDS);
		st_ok        = lane9 < 9'(MEMORY_WORDS);
		host_mem_ok  = haddr9 < 9'(MEMORY_WORDS);
		host_lane_ok = 6'(haddr_q) < 6'(LANES);
		dreg_ok      = 5'(dreg_q) < 5'(REGISTERS);
		sreg_ok      = 5'(sreg_q) < 5'(REGISTERS);
		oreg_ok      = 5'(oreg_q) < 5'(REGISTERS);
		last_lane    = lane_q == LW'(LANES - 1);
		clr_last     = clr_q == CLW'(CLR_DEPTH - 1);
		a_val        = sreg_ok ? rf_a_q : 32'd0;
		b_val        = useimm_q ? imm_q : (oreg_ok ? rf_b_q : 32'd0);
	end

	// per-lane execute decision
	logic        lx_wr, lx_gm, lx_sm, lx_fpu, lx_dz;
	logic [31:0] lx_val;
	status_t     lx_err;
	fpu_op_t     lx_fop;

	always_comb begin
		lx_wr  = 1'b0;
		lx_gm  = 1'b0;
		lx_sm  = 1'b0;
		lx_fpu = 1'b0;
		lx_dz  = 1'b0;
		lx_val = a_val;
		lx_err = ST_OK;
		lx_fop = FOP_ADD;
		unique case (opc_q)
			OP_ADD: begin
				lx_fpu = 1'b1;
			end
			OP_SUB: begin
				lx_fpu = 1'b1;
				lx_fop = FOP_SUB;
			end
			OP_MUL: begin
				lx_fpu = 1'b1;
				lx_fop = FOP_MUL;
			end
			OP_DIV: begin
				lx_fop = FOP_DIV;
				if (b_val[30:0] == 31'd0) begin
					lx_dz  = 1'b1;
					lx_err = ST_DIV_ZERO;
				end else begin
					lx_fpu = 1'b1;
				end
			end
			OP_NEG: begin
				lx_wr = 1'b1;
				if ((&a_val[30:23]) && (|a_val[22:0]))
					lx_val = CANON_NAN;
				else
					lx_val = {~a_val[31], a_val[30:0]};
			end
			OP_LD: begin
				if (mem_ok) begin
					lx_wr  = 1'b1;
					lx_val = (space_q == SPACE_GLOBAL) ? gm_q : sm_q;
				end else begin
					lx_err = (space_q == SPACE_GLOBAL) ? ST_GLOBAL_OOB : ST_SHARED_OOB;
				end
			end
			OP_ST: begin
				if (st_ok) begin
					lx_gm = space_q == SPACE_GLOBAL;
					lx_sm = space_q != SPACE_GLOBAL;
				end else begin
					lx_err = (space_q == SPACE_GLOBAL) ? ST_GLOBAL_OOB : ST_SHARED_OOB;
				end
			end
			OP_MOV: begin
				lx_wr = 1'b1;
			end
			default: ;
		endcase
	end

	assign fpu_req.start = (state_q == S_LANE_EX) && lx_fpu;
	assign fpu_req.op    = lx_fop;

	swfe_fpu u_fpu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (fpu_req),
		.op_a   (a_val),
		.op_b   (b_val),
		.rsp    (fpu_rsp)
	);

	// memory port selection
	logic           rf_we, gm_we, sm_we;
	logic [RFW-1:0] rf_wa, rf_ra, rf_rb;
	logic [MAW-1:0] gm_wa, sm_wa, mem_ra;
	logic [31:0]    rf_wd, gm_wd, sm_wd;

	always_comb begin
		rf_we  = 1'b0;
		gm_we  = 1'b0;
		sm_we  = 1'b0;
		rf_wa  = rf_idx(6'(lane_q), dreg_q);
		rf_wd  = lx_val;
		gm_wa  = lane9[MAW-1:0];
		gm_wd  = a_val;
		sm_wa  = lane9[MAW-1:0];
		sm_wd  = a_val;
		rf_ra  = rf_idx(6'(lane_q), sreg_q);
		rf_rb  = rf_idx(6'(lane_q), oreg_q);
		mem_ra = mem_addr9[MAW-1:0];
		priority case (1'b1)
			state_q == S_CLEAR: begin
				rf_we = {1'b0, clr_q} < (CLW + 1)'(RF_DEPTH);
				gm_we = {1'b0, clr_q} < (CLW + 1)'(MEMORY_WORDS);
				sm_we = gm_we;
				rf_wa = clr_q[RFW-1:0];
				gm_wa = clr_q[MAW-1:0];
				sm_wa = clr_q[MAW-1:0];
				rf_wd = '0;
				gm_wd = '0;
				sm_wd = '0;
			end
			state_q == S_DISPATCH: begin
				gm_we  = (req_q == REQ_HOST_WR) && host_mem_ok;
				gm_wa  = haddr9[MAW-1:0];
				gm_wd  = hdata_q;
				rf_ra  = rf_idx(6'(haddr_q), dreg_q);
				mem_ra = haddr9[MAW-1:0];
			end
			state_q == S_LANE_EX: begin
				rf_we = lx_wr && dreg_ok;
				gm_we = lx_gm;
				sm_we = lx_sm;
			end
			state_q == S_FPU_WAIT: begin
				rf_we = fpu_rsp.done && dreg_ok;
				rf_wd = fpu_rsp.result;
			end
			default: ;
		endcase
	end

	// storage arrays with registered reads
	always_ff @(posedge clk) begin
		if (rf_we)
			rf_mem[rf_wa] <= rf_wd;
		if (gm_we)
			gm_mem[gm_wa] <= gm_wd;
		if (sm_we)
			sm_mem[sm_wa] <= sm_wd;
		rf_a_q <= rf_mem[rf_ra];
		rf_b_q <= rf_mem[rf_rb];
		gm_q   <= gm_mem[mem_ra];
		sm_q   <= sm_mem[mem_ra];
	end

	// request field capture
	always_ff @(posedge clk) begin
		if (in_acc) begin
			req_q     <= s_axis_tuser[1:0];
			opc_q     <= s_axis_tdata[3:0];
			dreg_q    <= s_axis_tdata[5:4];
			sreg_q    <= s_axis_tdata[7:6];
			oreg_q    <= s_axis_tdata[9:8];
			useimm_q  <= s_axis_tdata[10];
			imm_q     <= s_axis_tdata[42:11];
			space_q   <= s_axis_tdata[44:43];
			uselane_q <= s_axis_tdata[45];
			maddr_q   <= s_axis_tdata[53:46];
			haddr_q   <= s_axis_tdata[55:54];
			hdata_q   <= s_axis_tdata[87:56];
		end
	end

	// low four lane bits for the result word
	logic [LANES+3:0] act_ext, divz_ext;
	assign act_ext  = {4'b0000, lane_active_q};
	assign divz_ext = {4'b0000, divz_q};

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_CLEAR;
			clr_q         <= '0;
			lane_q        <= '0;
			lane_active_q <= '1;
			divz_q        <= '0;
			status_q      <= ST_OK;
			rdata_q       <= '0;
			m_tvalid_q    <= 1'b0;
			m_tdata_q     <= '0;
		end else begin
			// the result state reloads the output itself
			if (m_tvalid_q && m_axis_tready && state_q != S_RESULT)
				m_tvalid_q <= 1'b0;
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + CLW'(1);
					if (clr_last)
						state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (in_acc) begin
						status_q <= ST_OK;
						divz_q   <= '0;
						rdata_q  <= '0;
						state_q  <= S_DISPATCH;
					end
				end
				S_DISPATCH: begin
					if (req_q == REQ_HOST_WR) begin
						state_q <= S_RESULT;
					end else if (req_q == REQ_HOST_RD || req_q == REQ_REG_RD) begin
						state_q <= S_HOST_RD;
					end else if (lane_active_q == '0 || opc_q > OP_HALT) begin
						state_q <= S_RESULT;
					end else if (opc_q == OP_HALT) begin
						lane_active_q <= '0;
						state_q       <= S_RESULT;
					end else if ((opc_q == OP_LD || opc_q == OP_ST) && space_q > SPACE_SHARED) begin
						status_q <= ST_BAD_SPACE;
						state_q  <= S_RESULT;
					end else begin
						lane_q  <= '0;
						state_q <= S_LANE_RD;
					end
				end
				S_HOST_RD: begin
					if (req_q == REQ_HOST_RD)
						rdata_q <= host_mem_ok ? gm_q : 32'd0;
					else
						rdata_q <= (host_lane_ok && dreg_ok) ? rf_a_q : 32'd0;
					state_q <= S_RESULT;
				end
				S_LANE_RD: begin
					// inactive lanes are skipped
					if (lane_active_q[lane_q]) begin
						state_q <= S_LANE_EX;
					end else if (last_lane) begin
						state_q <= S_RESULT;
					end else begin
						lane_q <= lane_q + LW'(1);
					end
				end
				S_LANE_EX: begin
					if (status_q == ST_OK)
						status_q <= lx_err;
					if (lx_dz)
						divz_q[lane_q] <= 1'b1;
					if (lx_fpu) begin
						state_q <= S_FPU_WAIT;
					end else if (last_lane) begin
						state_q <= S_RESULT;
					end else begin
						lane_q  <= lane_q + LW'(1);
						state_q <= S_LANE_RD;
					end
				end
				S_FPU_WAIT: begin
					if (fpu_rsp.done) begin
						if (last_lane) begin
							state_q <= S_RESULT;
						end else begin
							lane_q  <= lane_q + LW'(1);
							state_q <= S_LANE_RD;
						end
					end
				end
				S_RESULT: begin
					if (!m_tvalid_q || m_axis_tready) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= {4'b0000, rdata_q, lane_active_q == '0,
							act_ext[3:0], divz_ext[3:0], status_q};
						state_q    <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign m_axis_tvalid = m_tvalid_q;
	assign m_axis_tdata  = m_tdata_q;

	a_out_from_result: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid_q) |-> $past(state_q == S_RESULT))
		else $error("result word loaded outside result state");
	a_halt_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(lane_active_q == '0) |=> (lane_active_q == '0))
		else $error("halted warp came back to life");
	a_fpu_start: assert property (@(posedge clk) disable iff (!arst_n)
		fpu_req.start |=> state_q == S_FPU_WAIT)
		else $error("fpu started without waiting for it");
	a_fpu_done: assert property (@(posedge clk) disable iff (!arst_n)
		fpu_rsp.done |-> state_q == S_FPU_WAIT)
		else $error("fpu result with no lane waiting");

endmodule
`default_nettype wire

// File: src/swfe_fpu.sv
`default_nettype none
// Iterative binary32 add/sub/mul/div, round to nearest even, full subnormal support.
module swfe_fpu (
	input  logic                clk,
	input  logic                arst_n,
	input  swfe_pkg::fpu_req_t  req,
	input  logic [31:0]         op_a,
	input  logic [31:0]         op_b,
	output swfe_pkg::fpu_rsp_t  rsp
);
	import swfe_pkg::*;

	typedef enum logic [9:0] {
		F_IDLE    = 10'b00_0000_0001,
		F_UNPACK  = 10'b00_0000_0010,
		F_PRENORM = 10'b00_0000_0100,
		F_ALIGN   = 10'b00_0000_1000,
		F_ADD     = 10'b00_0001_0000,
		F_MUL     = 10'b00_0010_0000,
		F_DIV     = 10'b00_0100_0000,
		F_NORM    = 10'b00_1000_0000,
		F_DENORM  = 10'b01_0000_0000,
		F_ROUND   = 10'b10_0000_0000
	} fstate_t;

	fstate_t            fst_q;
	fpu_op_t            fop_q;
	logic [31:0]        ra_q, rb_q;
	logic               sa_q, sb_q, rs_q, sub_q, stk_q, done_q;
	logic signed [10:0] ea_q, eb_q, re_q;
	logic [23:0]        ma_q, mb_q;
	logic [27:0]        rm_q, bm_q, smm_q;
	logic [24:0]        rem_q;
	logic [26:0]        quo_q;
	logic [4:0]         cnt_q;
	logic [31:0]        res_q;

	// operand classification
	logic [7:0]  a_exp, b_exp;
	logic [22:0] a_frac, b_frac;
	logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero, sbe, sx;
	logic        spec;
	logic [31:0] spec_val;

	always_comb begin
		a_exp  = ra_q[30:23];
		b_exp  = rb_q[30:23];
		a_frac = ra_q[22:0];
		b_frac = rb_q[22:0];
		a_nan  = (&a_exp) & (|a_frac);
		b_nan  = (&b_exp) & (|b_frac);
		a_inf  = (&a_exp) & ~(|a_frac);
		b_inf  = (&b_exp) & ~(|b_frac);
		a_zero = ~(|ra_q[30:0]);
		b_zero = ~(|rb_q[30:0]);
		sbe    = rb_q[31] ^ (fop_q == FOP_SUB);
		sx     = ra_q[31] ^ rb_q[31];
		spec     = 1'b1;
		spec_val = CANON_NAN;
		unique case (fop_q)
			FOP_ADD, FOP_SUB: begin
				if (a_nan || b_nan || (a_inf && b_inf && (ra_q[31] != sbe)))
					spec_val = CANON_NAN;
				else if (a_inf)
					spec_val = {ra_q[31], 8'hFF, 23'd0};
				else if (b_inf)
					spec_val = {sbe, 8'hFF, 23'd0};
				else
					spec = 1'b0;
			end
			FOP_MUL: begin
				if (a_nan || b_nan || (a_inf && b_zero) || (b_inf && a_zero))
					spec_val = CANON_NAN;
				else if (a_inf || b_inf)
					spec_val = {sx, 8'hFF, 23'd0};
				else if (a_zero || b_zero)
					spec_val = {sx, 31'd0};
				else
					spec = 1'b0;
			end
			default: begin
				if (a_nan || b_nan || (a_inf && b_inf) || (a_zero && b_zero))
					spec_val = CANON_NAN;
				else if (a_inf || b_zero)
					spec_val = {sx, 8'hFF, 23'd0};
				else if (b_inf || a_zero)
					spec_val = {sx, 31'd0};
				else
					spec = 1'b0;
			end
		endcase
	end

	// alignment for add/sub
	logic               a_big;
	logic signed [10:0] big_e, dexp;
	logic [23:0]        big_m, sml_m;
	logic [27:0]        sml_ext, sml_sh;
	logic               sml_st;

	always_comb begin
		a_big   = (ea_q > eb_q) || ((ea_q == eb_q) && (ma_q >= mb_q));
		big_e   = a_big ? ea_q : eb_q;
		dexp    = a_big ? (ea_q - eb_q) : (eb_q - ea_q);
		big_m   = a_big ? ma_q : mb_q;
		sml_m   = a_big ? mb_q : ma_q;
		sml_ext = {1'b0, sml_m, 3'b000};
		if (dexp > 11'sd27) begin
			sml_sh = '0;
			sml_st = |sml_ext;
		end else begin
			sml_sh = sml_ext >> dexp[4:0];
			sml_st = |(sml_ext & ((28'd1 << dexp[4:0]) - 28'd1));
		end
	end

	// add, multiply and divide step
	logic [27:0] sum;
	logic [47:0] prod;
	logic        q_ge;
	logic [24:0] rem_sub, rem_nx;
	logic [26:0] quo_nx;

	always_comb begin
		sum     = sub_q ? (bm_q - smm_q) : (bm_q + smm_q);
		prod    = ma_q * mb_q;
		q_ge    = rem_q >= {1'b0, mb_q};
		rem_sub = q_ge ? (rem_q - {1'b0, mb_q}) : rem_q;
		rem_nx  = {rem_sub[23:0], 1'b0};
		quo_nx  = {quo_q[25:0], q_ge};
	end

	// rounding and packing
	logic               rnd_inc;
	logic [24:0]        mant;
	logic signed [10:0] e_fin;
	logic [22:0]        frac_fin;
	logic [31:0]        packed_res;

	always_comb begin
		rnd_inc  = rm_q[2] & (rm_q[1] | rm_q[0] | stk_q | rm_q[3]);
		mant     = {1'b0, rm_q[26:3]} + {24'd0, rnd_inc};
		e_fin    = mant[24] ? (re_q + 11'sd1) : re_q;
		frac_fin = mant[24] ? mant[23:1] : mant[22:0];
		if (mant[24] || mant[23]) begin
			if (e_fin >= 11'sd255)
				packed_res = {rs_q, 8'hFF, 23'd0};
			else
				packed_res = {rs_q, e_fin[7:0], frac_fin};
		end else begin
			packed_res = {rs_q, 8'h00, frac_fin};
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fst_q  <= F_IDLE;
			fop_q  <= FOP_ADD;
			ra_q   <= '0;
			rb_q   <= '0;
			sa_q   <= 1'b0;
			sb_q   <= 1'b0;
			rs_q   <= 1'b0;
			sub_q  <= 1'b0;
			stk_q  <= 1'b0;
			done_q <= 1'b0;
			ea_q   <= '0;
			eb_q   <= '0;
			re_q   <= '0;
			ma_q   <= '0;
			mb_q   <= '0;
			rm_q   <= '0;
			bm_q   <= '0;
			smm_q  <= '0;
			rem_q  <= '0;
			quo_q  <= '0;
			cnt_q  <= '0;
			res_q  <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (fst_q)
				F_IDLE: begin
					if (req.start) begin
						fop_q <= req.op;
						ra_q  <= op_a;
						rb_q  <= op_b;
						fst_q <= F_UNPACK;
					end
				end
				F_UNPACK: begin
					if (spec) begin
						res_q  <= spec_val;
						done_q <= 1'b1;
						fst_q  <= F_IDLE;
					end else begin
						ea_q  <= (a_exp == 8'd0) ? 11'sd1 : $signed({3'b000, a_exp});
						eb_q  <= (b_exp == 8'd0) ? 11'sd1 : $signed({3'b000, b_exp});
						ma_q  <= {|a_exp, a_frac};
						mb_q  <= {|b_exp, b_frac};
						sa_q  <= ra_q[31];
						sb_q  <= sbe;
						sub_q <= ra_q[31] != sbe;
						if (fop_q == FOP_ADD || fop_q == FOP_SUB)
							fst_q <= F_ALIGN;
						else
							fst_q <= F_PRENORM;
					end
				end
				F_PRENORM: begin
					// bring subnormal mantissas up to a leading one
					if (ma_q[23] && mb_q[23]) begin
						rs_q <= sa_q ^ sb_q;
						if (fop_q == FOP_MUL) begin
							fst_q <= F_MUL;
						end else begin
							rem_q <= {1'b0, ma_q};
							quo_q <= '0;
							cnt_q <= '0;
							re_q  <= ea_q - eb_q + 11'sd127;
							fst_q <= F_DIV;
						end
					end else begin
						if (!ma_q[23]) begin
							ma_q <= {ma_q[22:0], 1'b0};
							ea_q <= ea_q - 11'sd1;
						end
						if (!mb_q[23]) begin
							mb_q <= {mb_q[22:0], 1'b0};
							eb_q <= eb_q - 11'sd1;
						end
					end
				end
				F_ALIGN: begin
					bm_q  <= {1'b0, big_m, 3'b000};
					smm_q <= {sml_sh[27:1], sml_sh[0] | sml_st};
					re_q  <= big_e;
					rs_q  <= a_big ? sa_q : sb_q;
					fst_q <= F_ADD;
				end
				F_ADD: begin
					rm_q  <= sum;
					stk_q <= 1'b0;
					// exact cancellation gives +0
					if (sum == 28'd0 && sub_q)
						rs_q <= 1'b0;
					fst_q <= F_NORM;
				end
				F_MUL: begin
					rm_q  <= prod[47:20];
					stk_q <= |prod[19:0];
					re_q  <= ea_q + eb_q - 11'sd127;
					fst_q <= F_NORM;
				end
				F_DIV: begin
					rem_q <= rem_nx;
					quo_q <= quo_nx;
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd26) begin
						rm_q  <= {1'b0, quo_nx};
						stk_q <= |rem_nx;
						fst_q <= F_NORM;
					end
				end
				F_NORM: begin
					if (rm_q[27]) begin
						rm_q  <= {1'b0, rm_q[27:1]};
						stk_q <= stk_q | rm_q[0];
						re_q  <= re_q + 11'sd1;
					end else if (!rm_q[26] && rm_q != 28'd0 && re_q > 11'sd1) begin
						rm_q <= {rm_q[26:0], 1'b0};
						re_q <= re_q - 11'sd1;
					end else begin
						fst_q <= F_DENORM;
					end
				end
				F_DENORM: begin
					if (re_q < 11'sd1) begin
						if (rm_q == 28'd0) begin
							re_q <= 11'sd1;
						end else begin
							rm_q  <= {1'b0, rm_q[27:1]};
							stk_q <= stk_q | rm_q[0];
							re_q  <= re_q + 11'sd1;
						end
					end else begin
						fst_q <= F_ROUND;
					end
				end
				F_ROUND: begin
					res_q  <= packed_res;
					done_q <= 1'b1;
					fst_q  <= F_IDLE;
				end
				default: fst_q <= F_IDLE;
			endcase
		end
	end

	assign rsp.done   = done_q;
	assign rsp.result = res_q;

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q) else $error("fpu done held for two cycles");
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |-> fst_q == F_IDLE) else $error("fpu started while busy");
	a_div_count: assert property (@(posedge clk) disable iff (!arst_n)
		fst_q == F_DIV |-> cnt_q <= 5'd26) else $error("divide step count overrun");

endmodule
`default_nettype wire
